@@ hdl/ssid_pkg.sv @@
// ============================================================================
// Sorted set package
// Shared sizes, codes and cell command types for the sorted set store.
// ============================================================================
package ssid_pkg;

	// Store size and derived widths.
	localparam int CAPACITY    = 16;
	localparam int CNT_W       = $clog2(CAPACITY + 1);
	localparam int DATA_W      = 32;
	localparam int OUT_TDATA_W = ((2 * CNT_W + 7) / 8) * 8;

	// Operation codes carried on the input tuser.
	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_DELETE = 1'b1
	} op_t;

	// Result status codes carried on the output tuser.
	typedef enum logic [1:0] {
		ST_DONE = 2'd0,
		ST_DUP  = 2'd1,
		ST_MISS = 2'd2,
		ST_FULL = 2'd3
	} status_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_DEC,
		S_UPD
	} state_t;

	// Command broadcast from the controller to every cell.
	typedef struct packed {
		logic              compare;
		logic              ins;
		logic              del;
		logic              descending;
		logic [DATA_W-1:0] value;
	} cell_cmd_t;

endpackage

@@ hdl/ssid_cell.sv @@
// ============================================================================
// Sorted set cell
// Holds one entry, compares it against the broadcast value and shifts it
// toward a neighbor on insert or delete.
// ============================================================================
module ssid_cell
	import ssid_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cell_cmd_t         cmd,
	input  logic              occupied,   // entry index is below the count
	input  logic [DATA_W-1:0] left_entry,
	input  logic [DATA_W-1:0] right_entry,
	input  logic              seen_in,    // a failing cell exists to the left
	output logic              seen_out,
	output logic              at_pos,
	output logic              match,
	output logic [DATA_W-1:0] entry
);

	logic [DATA_W-1:0] entry_q;
	logic              fail_s1;
	logic              eq_s1;
	logic              ahead;

	// The stored entry comes strictly before the value in the chosen order.
	always_comb begin
		if (cmd.descending) begin
			ahead = $signed(entry_q) > $signed(cmd.value);
		end else begin
			ahead = $signed(entry_q) < $signed(cmd.value);
		end
	end

	// Compare flags; an unoccupied cell always fails, which caps the position
	// at the count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fail_s1 <= 1'b0;
			eq_s1   <= 1'b0;
		end else if (cmd.compare) begin
			fail_s1 <= !occupied || !ahead;
			eq_s1   <= occupied && (entry_q == cmd.value);
		end
	end

	// Priority chain: the first failing cell marks the position.
	assign seen_out = seen_in | fail_s1;
	assign at_pos   = fail_s1 & !seen_in;
	assign match    = at_pos & eq_s1;

	// Shift up on insert, shift down on delete.
	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (seen_in) begin
				entry_q <= left_entry;
			end else if (fail_s1) begin
				entry_q <= cmd.value;
			end
		end else if (cmd.del && seen_out) begin
			entry_q <= right_entry;
		end
	end

	assign entry = entry_q;

endmodule

@@ hdl/ssid_ctrl.sv @@
// ============================================================================
// Sorted set controller
// Runs the handshakes, sequences compare, decide and update, keeps the count
// and holds the result word.
// ============================================================================
module ssid_ctrl
	import ssid_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	// Input stream.
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [DATA_W-1:0]      s_tdata,
	input  logic                   s_tuser,
	// Output stream.
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,
	output logic [1:0]             m_tuser,
	// Configuration write.
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic                   cfg_data,
	// Cell row.
	input  logic [CAPACITY-1:0]    at_pos,
	input  logic [CAPACITY-1:0]    match,
	output logic [CAPACITY-1:0]    occupied,
	output cell_cmd_t              cmd
);

	state_t            state_q, state_d;
	logic              order_q;
	op_t               op_q;
	logic [DATA_W-1:0] value_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  pos_q;
	status_t           status_q;
	logic              ins_q;
	logic              del_q;
	logic              m_valid_q;
	logic [CNT_W-1:0]  out_pos_q;
	logic [CNT_W-1:0]  out_count_q;
	status_t           out_status_q;

	logic              found;
	logic              any_at;
	logic [CNT_W-1:0]  pos_enc;
	logic              out_free;
	logic              accept;
	logic              commit;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == S_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign out_free  = !m_valid_q || m_tready;
	assign commit    = (state_q == S_UPD) && out_free;

	// Occupancy of each cell from the count.
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			occupied[i] = CNT_W'(i) < count_q;
		end
	end

	// Position from the one-hot marker; no marker means every slot is before.
	always_comb begin
		found   = |match;
		any_at  = |at_pos;
		pos_enc = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (at_pos[i]) begin
				pos_enc = pos_enc | CNT_W'(i);
			end
		end
		if (!any_at) begin
			pos_enc = CNT_W'(CAPACITY);
		end
	end

	// Next state and cell commands.
	always_comb begin
		state_d        = state_q;
		cmd.compare    = 1'b0;
		cmd.ins        = 1'b0;
		cmd.del        = 1'b0;
		cmd.descending = order_q;
		cmd.value      = value_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_CMP;
				end
			end
			S_CMP: begin
				cmd.compare = 1'b1;
				state_d     = S_DEC;
			end
			S_DEC: begin
				state_d = S_UPD;
			end
			S_UPD: begin
				if (out_free) begin
					cmd.ins = ins_q;
					cmd.del = del_q;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Order register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			order_q <= cfg_data;
		end
	end

	// Input word capture.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= op_t'(s_tuser);
			value_q <= s_tdata;
		end
	end

	// Decision from the cell flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ins_q    <= 1'b0;
			del_q    <= 1'b0;
			pos_q    <= '0;
			status_q <= ST_DONE;
		end else if (state_q == S_DEC) begin
			pos_q <= pos_enc;
			ins_q <= 1'b0;
			del_q <= 1'b0;
			if (op_q == OP_INSERT) begin
				if (found) begin
					status_q <= ST_DUP;
				end else if (count_q == CNT_W'(CAPACITY)) begin
					status_q <= ST_FULL;
				end else begin
					status_q <= ST_DONE;
					ins_q    <= 1'b1;
				end
			end else begin
				if (!found) begin
					status_q <= ST_MISS;
				end else begin
					status_q <= ST_DONE;
					del_q    <= 1'b1;
				end
			end
		end
	end

	// Count update at commit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (commit) begin
			if (ins_q) begin
				count_q <= count_q + CNT_W'(1);
			end else if (del_q) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// Output register; it frees the sequencer while a result waits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (commit) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_pos_q    <= pos_q;
			out_status_q <= status_q;
			if (ins_q) begin
				out_count_q <= count_q + CNT_W'(1);
			end else if (del_q) begin
				out_count_q <= count_q - CNT_W'(1);
			end else begin
				out_count_q <= count_q;
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {{(OUT_TDATA_W - 2 * CNT_W){1'b0}}, out_count_q, out_pos_q};

endmodule

@@ hdl/sorted_set_insert_delete.sv @@
// ============================================================================
// Sorted set store
// Keeps up to CAPACITY distinct signed 32-bit values in sorted order and
// serves insert and delete requests.
// ============================================================================
// Each input word passes through these steps in order: the block accepts it,
// every cell compares its entry with the value, the priority chain across
// the cell row picks the position and the status, and the cells shift and
// the result word is loaded. The next word is accepted in the cycle after
// that, so a new word is taken only once the last one is through. The
// result sits in an output register, so a new word
// is taken while an earlier result waits; the update stalls only when a
// second result would overwrite one that has not been taken. The order bit
// may be written only while the block is idle; stored values are not
// re-sorted when it changes.
module sorted_set_insert_delete
	import ssid_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [DATA_W-1:0]      s_tdata,  // value [31:0]
	input  logic                   s_tuser,  // operation [0]
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,  // position [4:0], count [9:5]
	output logic [1:0]             m_tuser,  // status [1:0]
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic                   cfg_data  // order_descending
);

	cell_cmd_t           cmd;
	logic [CAPACITY-1:0] occupied;
	logic [CAPACITY-1:0] at_pos;
	logic [CAPACITY-1:0] match;
	logic [CAPACITY:0]   seen;
	logic [DATA_W-1:0]   entry [CAPACITY];

	ssid_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.at_pos    (at_pos),
		.match     (match),
		.occupied  (occupied),
		.cmd       (cmd)
	);

	// Row of cells; the chain starts with nothing seen.
	assign seen[0] = 1'b0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_W-1:0] left_w;
		logic [DATA_W-1:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = cmd.value;
		end else begin : g_inner_l
			assign left_w = entry[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_w = entry[i];
		end else begin : g_inner_r
			assign right_w = entry[i+1];
		end

		ssid_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmd         (cmd),
			.occupied    (occupied[i]),
			.left_entry  (left_w),
			.right_entry (right_w),
			.seen_in     (seen[i]),
			.seen_out    (seen[i+1]),
			.at_pos      (at_pos[i]),
			.match       (match[i]),
			.entry       (entry[i])
		);
	end

endmodule

@@ hdl/ssid_check.sv @@
// ============================================================================
// Sorted set port checker
// Watches the top-level ports for sequencing and result consistency.
// ============================================================================
module ssid_check
	import ssid_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata,
	input logic [1:0]             m_tuser
);

	// One word is worked on at a time.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while a word is in work");

	// A stalled result holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// A full status only comes with a full store.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_FULL) |-> (m_tdata[2*CNT_W-1:CNT_W] == CNT_W'(CAPACITY)))
		else $error("full status without full count");

	// A duplicate is found inside the stored range.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_DUP) |-> (m_tdata[CNT_W-1:0] < m_tdata[2*CNT_W-1:CNT_W]))
		else $error("duplicate position beyond count");

	// The count never exceeds the capacity.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[2*CNT_W-1:CNT_W] <= CNT_W'(CAPACITY)))
		else $error("count beyond capacity");

endmodule

bind sorted_set_insert_delete ssid_check u_ssid_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

@@ tb/sorted_set_insert_delete_checker.sv @@
`timescale 1ns / 100ps
// ============================================================================
// Sorted set store checker
// Watches the request, result and order channels of the sorted set store.
// It keeps its own copy of the stored values, works out the expected status,
// position and count for every accepted request word, and compares each
// accepted result word against the oldest expectation.
// ============================================================================
module sorted_set_insert_delete_checker
	import ssid_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	input  logic [DATA_W-1:0]      s_tdata,  // value [31:0]
	input  logic                   s_tuser,  // operation [0]
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic [OUT_TDATA_W-1:0] m_tdata,  // position [4:0], count [9:5]
	input  logic [1:0]             m_tuser,  // status [1:0]
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic                   cfg_data, // order_descending
	output int                     failures,
	output int                     results_seen,
	output int                     pending
);

	typedef struct packed {
		status_t          status;
		logic [CNT_W-1:0] position;
		logic [CNT_W-1:0] count;
	} set_result_t;

	// Shadow copy of the store and its order bit.
	logic [DATA_W-1:0] shadow_vals [CAPACITY];
	int                shadow_count;
	logic              shadow_desc;

	set_result_t expected_results [$];
	int          fail_n;
	int          seen_n;

	// True when a stored value sorts strictly ahead of x in the current order.
	function automatic bit sorts_ahead(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] x);
		if (shadow_desc)
			return $signed(a) > $signed(x);
		return $signed(a) < $signed(x);
	endfunction

	// Apply one request to the shadow store and return the result it must give.
	function automatic set_result_t apply_request(input op_t op, input logic [DATA_W-1:0] x);
		set_result_t r;
		int          pos;
		int          n;
		bit          hit;
		n = shadow_count;
		pos = 0;
		while (pos < n && sorts_ahead(shadow_vals[pos], x))
			pos++;
		hit = (pos < n) && (shadow_vals[pos] == x);
		r.status = ST_DONE;
		if (op == OP_INSERT) begin
			if (hit) begin
				r.status = ST_DUP;
			end else if (n >= CAPACITY) begin
				r.status = ST_FULL;
			end else begin
				for (int i = n; i > pos; i--)
					shadow_vals[i] = shadow_vals[i-1];
				shadow_vals[pos] = x;
				n++;
			end
		end else begin
			if (!hit) begin
				r.status = ST_MISS;
			end else begin
				for (int i = pos; i + 1 < n; i++)
					shadow_vals[i] = shadow_vals[i+1];
				n--;
			end
		end
		shadow_count = n;
		r.position = CNT_W'(pos);
		r.count = CNT_W'(n);
		return r;
	endfunction

	// Report one field that differs from its expectation.
	function automatic void check_field(input string name, input int exp, input logic [7:0] act);
		if (act !== 8'(exp)) begin
			fail_n++;
			$error("%s: expected %0d, got %0d", name, exp, act);
		end
	endfunction

	// Order writes, result compares and request predictions, one edge at a time.
	always @(posedge clk or negedge arst_n) begin
		set_result_t exp;
		if (!arst_n) begin
			shadow_count = 0;
			shadow_desc = 1'b0;
			expected_results.delete();
			fail_n = 0;
			seen_n = 0;
			failures <= 0;
			results_seen <= 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				shadow_desc = cfg_data;
			// The result leaving now belongs to an earlier request word.
			if (m_tvalid && m_tready) begin
				seen_n++;
				if (expected_results.size() == 0) begin
					fail_n++;
					$error("result word with no request waiting: status %0d", m_tuser);
				end else begin
					exp = expected_results.pop_front();
					check_field("status", int'(exp.status), 8'(m_tuser));
					check_field("position", int'(exp.position), 8'(m_tdata[CNT_W-1:0]));
					check_field("count", int'(exp.count), 8'(m_tdata[2*CNT_W-1:CNT_W]));
				end
			end
			if (s_tvalid && s_tready)
				expected_results.push_back(apply_request(op_t'(s_tuser), s_tdata));
			failures <= fail_n;
			results_seen <= seen_n;
			pending <= expected_results.size();
		end
	end

endmodule

@@ tb/sorted_set_insert_delete_tb.sv @@
`timescale 1ns / 100ps
// ============================================================================
// Sorted set store testbench
// Drives insert and delete request words into the sorted set store in both
// orders, with random stalls on both streams, and lets the checker predict
// and compare every result word.
// ============================================================================
module sorted_set_insert_delete_tb;
	import ssid_pkg::*;

	localparam int SETTLE      = 8;
	localparam int CYCLE_LIMIT = 400000;
	localparam int POOL_MAX    = 24;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [DATA_W-1:0]      s_tdata;  // value [31:0]
	logic                   s_tuser;  // operation [0]
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;  // position [4:0], count [9:5]
	logic [1:0]             m_tuser;  // status [1:0]
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic                   cfg_data;

	int failures;
	int results_seen;
	int pending;
	int words_sent;
	int order_writes;
	int cycles;
	bit tx_gaps;
	bit rx_gaps;

	// Values inserted lately, so that deletes and duplicates hit stored entries.
	logic [DATA_W-1:0] value_pool [$];

	sorted_set_insert_delete dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	sorted_set_insert_delete_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.failures     (failures),
		.results_seen (results_seen),
		.pending      (pending)
	);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("sorted_set_insert_delete: mismatch");
			$finish;
		end
	end

	// Result side: ready drops in random bursts while idling is enabled.
	initial begin
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (rx_gaps && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	// Present one request word and hold it until it is taken.
	task automatic send_word(input op_t op, input logic [DATA_W-1:0] v);
		if (tx_gaps && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= v;
		s_tuser <= op;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		words_sent++;
	endtask

	// Stop sending and wait until every result word has come back.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (results_seen != words_sent)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Write the order bit; only called with the store idle.
	task automatic write_order(input logic desc);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data <= desc;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		order_writes++;
	endtask

	// Value mix: full-range random, pool hits and neighbors, small and extreme.
	function automatic logic [DATA_W-1:0] pick_value();
		logic [DATA_W-1:0] base;
		case ($urandom_range(0, 9))
			4, 5, 6: begin
				if (value_pool.size() == 0)
					return $urandom;
				base = value_pool[$urandom_range(0, value_pool.size() - 1)];
				case ($urandom_range(0, 2))
					0: return base + 1;
					1: return base - 1;
					default: return base;
				endcase
			end
			7: return $urandom_range(0, 15) - 8;
			8: begin
				case ($urandom_range(0, 3))
					0: return 32'h8000_0000;
					1: return 32'h7fff_ffff;
					2: return 32'h0000_0000;
					default: return 32'hffff_ffff;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	// Random requests; deletes mostly aim at values that were inserted.
	task automatic run_random(input int n, input int ins_pct);
		op_t               op;
		logic [DATA_W-1:0] v;
		repeat (n) begin
			op = ($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_DELETE;
			if (op == OP_DELETE && value_pool.size() != 0 && $urandom_range(0, 9) < 7)
				v = value_pool[$urandom_range(0, value_pool.size() - 1)];
			else
				v = pick_value();
			send_word(op, v);
			if (op == OP_INSERT) begin
				value_pool.push_back(v);
				if (value_pool.size() > POOL_MAX)
					void'(value_pool.pop_front());
			end
		end
	endtask

	// Stimulus and verdict.
	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = OP_INSERT;
		cfg_valid = 1'b0;
		cfg_data = 1'b0;
		words_sent = 0;
		order_writes = 0;
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Ascending: empty delete, extremes, duplicate, front and end deletes.
		write_order(1'b0);
		send_word(OP_DELETE, 32'd5);
		send_word(OP_INSERT, 32'd0);
		send_word(OP_INSERT, 32'h7fff_ffff);
		send_word(OP_INSERT, 32'h8000_0000);
		send_word(OP_INSERT, 32'd0);
		send_word(OP_INSERT, 32'hffff_ffff);
		send_word(OP_DELETE, 32'h8000_0000);
		send_word(OP_DELETE, 32'h7fff_ffff);
		send_word(OP_DELETE, 32'd7);

		// Order flipped with values stored: searches run on unsorted contents.
		write_order(1'b1);
		send_word(OP_INSERT, 32'd3);
		send_word(OP_DELETE, 32'd0);

		// Fill the store, then a full insert and a duplicate while full.
		for (int k = 0; k < 14; k++)
			send_word(OP_INSERT, 32'd1000 + k);
		send_word(OP_INSERT, 32'd2000);
		send_word(OP_INSERT, 32'd1000);

		// Random phases over both orders with different insert weights.
		write_order(1'b0);
		run_random(330, 60);
		write_order(1'b1);
		run_random(330, 45);
		write_order(1'b0);
		run_random(330, 50);

		// Last phase runs at full rate on both streams.
		write_order(1'b1);
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		run_random(330, 55);
		drain_results();

		$display("Covered %0d request words and %0d result words in both orders,",
			words_sent, results_seen);
		$display("with %0d order writes, a full store and stalls on both streams.",
			order_writes);
		if (failures == 0 && pending == 0)
			$display("sorted_set_insert_delete: match");
		else
			$display("sorted_set_insert_delete: mismatch");
		$finish;
	end

endmodule
